// ----- rtl/cvm_pkg.sv -----
// ----------------------------------------------------------------------------
// cvm_pkg: shared types and helpers for the camera view matrix builder
// request and result payloads, vector types, latencies, rounding helpers
// ----------------------------------------------------------------------------
`default_nettype none

package cvm_pkg;

  // latency of one normalize unit, input sample to output register
  localparam int unsigned NORM_LAT  = 52;
  // acceptance edge to result strobe, in clock edges
  localparam int unsigned TOTAL_LAT = 2 * NORM_LAT + 8;

  typedef struct packed {
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic signed [15:0] look_in_x;
    logic signed [15:0] look_in_y;
    logic signed [15:0] look_in_z;
    logic signed [15:0] right_in_x;
    logic signed [15:0] right_in_y;
    logic signed [15:0] right_in_z;
  } cvm_req_t;

  typedef struct packed {
    logic signed [15:0] right_out_x;
    logic signed [15:0] right_out_y;
    logic signed [15:0] right_out_z;
    logic signed [15:0] up_out_x;
    logic signed [15:0] up_out_y;
    logic signed [15:0] up_out_z;
    logic signed [15:0] look_out_x;
    logic signed [15:0] look_out_y;
    logic signed [15:0] look_out_z;
    logic signed [31:0] trans_x;
    logic signed [31:0] trans_y;
    logic signed [31:0] trans_z;
  } cvm_res_t;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] z;
  } cvm_vec16_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } cvm_vec32_t;

  // round q.28 to q1.14 half away from zero, saturate to 16 bits
  function automatic logic [15:0] rnd_sat16(input logic [32:0] x);
    logic        neg;
    logic [32:0] mag;
    logic [32:0] r;
    logic [15:0] res;
    neg = x[32];
    mag = neg ? (33'd0 - x) : x;
    r   = (mag + 33'd8192) >> 14;
    if (!neg && r > 33'd32767) begin
      res = 16'h7fff;
    end else if (neg && r > 33'd32768) begin
      res = 16'h8000;
    end else begin
      res = neg ? (16'd0 - r[15:0]) : r[15:0];
    end
    return res;
  endfunction

  // negate q.30 dot product, round to q16.16 half away from zero, saturate
  function automatic logic [31:0] rnd_sat32(input logic [49:0] d);
    logic [50:0] x;
    logic        neg;
    logic [50:0] mag;
    logic [50:0] r;
    logic [31:0] res;
    x   = 51'd0 - {d[49], d};
    neg = x[50];
    mag = neg ? (51'd0 - x) : x;
    r   = (mag + 51'd8192) >> 14;
    if (!neg && r > 51'h7fff_ffff) begin
      res = 32'h7fff_ffff;
    end else if (neg && r > 51'h8000_0000) begin
      res = 32'h8000_0000;
    end else begin
      res = neg ? (32'd0 - r[31:0]) : r[31:0];
    end
    return res;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/cvm_norm3.sv -----
// ----------------------------------------------------------------------------
// cvm_norm3: pipelined 3-vector normalize to q1.14
// block scale, squares, bit-serial square root stages, restoring divide stages
// ----------------------------------------------------------------------------
`default_nettype none

module cvm_norm3 (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  input  cvm_pkg::cvm_vec32_t in_vec_i,
  output logic                out_valid_o,
  output cvm_pkg::cvm_vec16_t out_vec_o
);
  import cvm_pkg::*;

  localparam int unsigned SQ_STEPS  = 30;
  localparam int unsigned DIV_STEPS = 15;

  // stage 1: magnitudes and maximum
  logic [31:0] s1_mag_q [3];
  logic [2:0]  s1_neg_q;
  logic [31:0] s1_max_q;
  logic        s1_v_q;
  logic [31:0] mag_d [3];
  logic [31:0] max_d;

  // stage 2: leading one
  logic [31:0] s2_mag_q [3];
  logic [2:0]  s2_neg_q;
  logic [4:0]  s2_pos_q;
  logic        s2_zero_q;
  logic        s2_v_q;
  logic [4:0]  pos_d;

  // stage 3: block scaled to [2^14, 2^15)
  logic [14:0] s3_m_q [3];
  logic [2:0]  s3_neg_q;
  logic        s3_zero_q;
  logic        s3_v_q;

  // stage 4: squares
  logic [29:0] s4_sq_q [3];
  logic [14:0] s4_m_q [3];
  logic [2:0]  s4_neg_q;
  logic        s4_zero_q;
  logic        s4_v_q;
  logic [31:0] sum_d;

  // square root stages, index 0 holds the radicand
  logic [59:0] sq_rem_q  [SQ_STEPS+1];
  logic [60:0] sq_root_q [SQ_STEPS+1];
  logic [14:0] sq_m_q    [SQ_STEPS+1][3];
  logic [2:0]  sq_neg_q  [SQ_STEPS+1];
  logic        sq_zero_q [SQ_STEPS+1];
  logic        sq_v_q    [SQ_STEPS+1];

  // divide stages, index 0 holds the rounded numerators
  logic [45:0] dv_rem_q  [DIV_STEPS+1][3];
  logic [14:0] dv_quo_q  [DIV_STEPS+1][3];
  logic [29:0] dv_den_q  [DIV_STEPS+1];
  logic [2:0]  dv_neg_q  [DIV_STEPS+1];
  logic        dv_zero_q [DIV_STEPS+1];
  logic        dv_v_q    [DIV_STEPS+1];

  logic [15:0] o_q [3];
  logic        o_v_q;

  always_comb begin
    mag_d[0] = in_vec_i.x[31] ? (32'd0 - in_vec_i.x) : in_vec_i.x;
    mag_d[1] = in_vec_i.y[31] ? (32'd0 - in_vec_i.y) : in_vec_i.y;
    mag_d[2] = in_vec_i.z[31] ? (32'd0 - in_vec_i.z) : in_vec_i.z;
    max_d    = mag_d[0];
    if (mag_d[1] > max_d) max_d = mag_d[1];
    if (mag_d[2] > max_d) max_d = mag_d[2];
  end

  always_comb begin
    pos_d = 5'd0;
    for (int b = 0; b < 32; b++) begin
      if (s1_max_q[b]) pos_d = 5'(b);
    end
  end

  assign sum_d = {2'b0, s4_sq_q[0]} + {2'b0, s4_sq_q[1]} + {2'b0, s4_sq_q[2]};

  always_ff @(posedge clk_i) begin
    s1_mag_q <= mag_d;
    s1_neg_q <= {in_vec_i.z[31], in_vec_i.y[31], in_vec_i.x[31]};
    s1_max_q <= max_d;

    s2_mag_q  <= s1_mag_q;
    s2_neg_q  <= s1_neg_q;
    s2_pos_q  <= pos_d;
    s2_zero_q <= (s1_max_q == 32'd0);

    for (int i = 0; i < 3; i++) begin
      if (s2_pos_q > 5'd14) begin
        s3_m_q[i] <= 15'(s2_mag_q[i] >> (s2_pos_q - 5'd14));
      end else begin
        s3_m_q[i] <= 15'(s2_mag_q[i] << (5'd14 - s2_pos_q));
      end
    end
    s3_neg_q  <= s2_neg_q;
    s3_zero_q <= s2_zero_q;

    for (int i = 0; i < 3; i++) begin
      s4_sq_q[i] <= 30'(s3_m_q[i]) * 30'(s3_m_q[i]);
    end
    s4_m_q    <= s3_m_q;
    s4_neg_q  <= s3_neg_q;
    s4_zero_q <= s3_zero_q;

    sq_rem_q[0]  <= {sum_d, 28'd0};
    sq_root_q[0] <= 61'd0;
    sq_m_q[0]    <= s4_m_q;
    sq_neg_q[0]  <= s4_neg_q;
    sq_zero_q[0] <= s4_zero_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q    <= 1'b0;
      s2_v_q    <= 1'b0;
      s3_v_q    <= 1'b0;
      s4_v_q    <= 1'b0;
      sq_v_q[0] <= 1'b0;
    end else begin
      s1_v_q    <= in_valid_i;
      s2_v_q    <= s1_v_q;
      s3_v_q    <= s2_v_q;
      s4_v_q    <= s3_v_q;
      sq_v_q[0] <= s4_v_q;
    end
  end

  // one root bit per stage
  for (genvar j = 0; j < SQ_STEPS; j++) begin : g_sqrt
    localparam logic [60:0] Bit = 61'd1 << (58 - 2 * j);
    logic [60:0] trial;
    assign trial = sq_root_q[j] + Bit;

    always_ff @(posedge clk_i) begin
      if ({1'b0, sq_rem_q[j]} >= trial) begin
        sq_rem_q[j+1]  <= 60'({1'b0, sq_rem_q[j]} - trial);
        sq_root_q[j+1] <= (sq_root_q[j] >> 1) + Bit;
      end else begin
        sq_rem_q[j+1]  <= sq_rem_q[j];
        sq_root_q[j+1] <= sq_root_q[j] >> 1;
      end
      sq_m_q[j+1]    <= sq_m_q[j];
      sq_neg_q[j+1]  <= sq_neg_q[j];
      sq_zero_q[j+1] <= sq_zero_q[j];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        sq_v_q[j+1] <= 1'b0;
      end else begin
        sq_v_q[j+1] <= sq_v_q[j];
      end
    end
  end

  // numerator: component scaled by 2^28 plus half the divisor
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      dv_rem_q[0][i] <= {3'b0, sq_m_q[SQ_STEPS][i], 28'd0}
                        + {17'd0, sq_root_q[SQ_STEPS][29:1]};
      dv_quo_q[0][i] <= 15'd0;
    end
    dv_den_q[0]  <= sq_root_q[SQ_STEPS][29:0];
    dv_neg_q[0]  <= sq_neg_q[SQ_STEPS];
    dv_zero_q[0] <= sq_zero_q[SQ_STEPS];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_v_q[0] <= 1'b0;
    end else begin
      dv_v_q[0] <= sq_v_q[SQ_STEPS];
    end
  end

  // one quotient bit per stage, msb first
  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    localparam int unsigned K = DIV_STEPS - 1 - j;
    logic [45:0] dsh;
    assign dsh = {16'd0, dv_den_q[j]} << K;

    always_ff @(posedge clk_i) begin
      for (int i = 0; i < 3; i++) begin
        if (dv_rem_q[j][i] >= dsh) begin
          dv_rem_q[j+1][i] <= dv_rem_q[j][i] - dsh;
          dv_quo_q[j+1][i] <= dv_quo_q[j][i] | (15'd1 << K);
        end else begin
          dv_rem_q[j+1][i] <= dv_rem_q[j][i];
          dv_quo_q[j+1][i] <= dv_quo_q[j][i];
        end
      end
      dv_den_q[j+1]  <= dv_den_q[j];
      dv_neg_q[j+1]  <= dv_neg_q[j];
      dv_zero_q[j+1] <= dv_zero_q[j];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_v_q[j+1] <= 1'b0;
      end else begin
        dv_v_q[j+1] <= dv_v_q[j];
      end
    end
  end

  // sign and zero-length cleanup
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < 3; i++) begin
      if (dv_zero_q[DIV_STEPS]) begin
        o_q[i] <= 16'd0;
      end else if (dv_neg_q[DIV_STEPS][i]) begin
        o_q[i] <= 16'd0 - {1'b0, dv_quo_q[DIV_STEPS][i]};
      end else begin
        o_q[i] <= {1'b0, dv_quo_q[DIV_STEPS][i]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      o_v_q <= 1'b0;
    end else begin
      o_v_q <= dv_v_q[DIV_STEPS];
    end
  end

  assign out_valid_o = o_v_q;
  assign out_vec_o   = {o_q[0], o_q[1], o_q[2]};

endmodule

`default_nettype wire

// ----- rtl/camera_view_matrix_build_core.sv -----
// ----------------------------------------------------------------------------
// camera_view_matrix_build_core: look-at view axes and translations
// orthonormal right/up/look axes in q1.14 and saturated q16.16 translations
// ----------------------------------------------------------------------------
// The core takes one camera request per clock and returns one result per
// request, in order, after two normalize pipelines of 52 stages each, set
// by their 30-stage square root and 15-stage divide, plus eight stages of
// input register, cross products, rounding and dot products.
// busy is always low: every start is taken. done_o strobes for a single
// cycle with res_o valid in that cycle only; the receiver must take it then.
// ----------------------------------------------------------------------------
`default_nettype none

module camera_view_matrix_build_core (
  input  wire               clk_i,
  input  wire               rst_ni,
  input  wire               start,
  output logic              busy,
  input  cvm_pkg::cvm_req_t req_i,
  output logic              done_o,
  output cvm_pkg::cvm_res_t res_o
);
  import cvm_pkg::*;

  localparam int unsigned D_RIN = NORM_LAT;          // rin to normalized look
  localparam int unsigned D_L   = NORM_LAT + 2;      // look to normalized up
  localparam int unsigned D_POS = 2 * NORM_LAT + 4;  // position to right axis

  // input register
  cvm_req_t   in_q;
  logic       v0_q;
  cvm_vec32_t look32;

  // first normalize: look
  logic       n1_v;
  cvm_vec16_t n1_l;

  // side delay lines
  cvm_vec16_t rin_dly_q [D_RIN];
  cvm_vec16_t l_dly_q   [D_L];
  logic [31:0] pos_dly_q [D_POS][3];

  // look x right_in
  logic signed [31:0] c1p_q [6];
  logic               c1p_v_q;
  cvm_vec32_t         c1d_q;
  logic               c1d_v_q;

  // second normalize: up
  logic       n2_v;
  cvm_vec16_t n2_u;

  // up x look, rounded to the right axis
  logic signed [31:0] c2p_q [6];
  logic               c2p_v_q;
  cvm_vec16_t         u_d1_q, l_d1_q;
  logic [15:0]        r_q [3];
  logic               r_v_q;
  cvm_vec16_t         u_d2_q, l_d2_q;

  // dot products against the position
  logic signed [47:0] dp_q [9];
  logic               dp_v_q;
  logic [15:0]        ax_dp_q [9];
  logic [49:0]        ds_q [3];
  logic               ds_v_q;
  logic [15:0]        ax_ds_q [9];

  cvm_res_t res_q;
  logic     done_q;

  logic signed [15:0] ax_r [9];

  // every request is taken, nothing downstream can stall
  assign busy = 1'b0;

  always_ff @(posedge clk_i) begin
    if (start) begin
      in_q <= req_i;
    end
  end

  assign look32 = {{{16{in_q.look_in_x[15]}}, in_q.look_in_x},
                   {{16{in_q.look_in_y[15]}}, in_q.look_in_y},
                   {{16{in_q.look_in_z[15]}}, in_q.look_in_z}};

  cvm_norm3 u_norm_look (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (v0_q),
    .in_vec_i    (look32),
    .out_valid_o (n1_v),
    .out_vec_o   (n1_l)
  );

  // delay lines keep side data beside the normalize pipelines
  always_ff @(posedge clk_i) begin
    rin_dly_q[0] <= {in_q.right_in_x, in_q.right_in_y, in_q.right_in_z};
    for (int i = 1; i < D_RIN; i++) rin_dly_q[i] <= rin_dly_q[i-1];
    l_dly_q[0] <= n1_l;
    for (int i = 1; i < D_L; i++) l_dly_q[i] <= l_dly_q[i-1];
    pos_dly_q[0][0] <= in_q.pos_x;
    pos_dly_q[0][1] <= in_q.pos_y;
    pos_dly_q[0][2] <= in_q.pos_z;
    for (int i = 1; i < D_POS; i++) pos_dly_q[i] <= pos_dly_q[i-1];
  end

  // look x right_in, products then differences
  always_ff @(posedge clk_i) begin
    c1p_q[0] <= n1_l.y * rin_dly_q[D_RIN-1].z;
    c1p_q[1] <= n1_l.z * rin_dly_q[D_RIN-1].y;
    c1p_q[2] <= n1_l.z * rin_dly_q[D_RIN-1].x;
    c1p_q[3] <= n1_l.x * rin_dly_q[D_RIN-1].z;
    c1p_q[4] <= n1_l.x * rin_dly_q[D_RIN-1].y;
    c1p_q[5] <= n1_l.y * rin_dly_q[D_RIN-1].x;
    c1d_q.x  <= c1p_q[0] - c1p_q[1];
    c1d_q.y  <= c1p_q[2] - c1p_q[3];
    c1d_q.z  <= c1p_q[4] - c1p_q[5];
  end

  cvm_norm3 u_norm_up (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (c1d_v_q),
    .in_vec_i    (c1d_q),
    .out_valid_o (n2_v),
    .out_vec_o   (n2_u)
  );

  // up x look, then round q.28 back to q1.14
  always_ff @(posedge clk_i) begin
    c2p_q[0] <= n2_u.y * l_dly_q[D_L-1].z;
    c2p_q[1] <= n2_u.z * l_dly_q[D_L-1].y;
    c2p_q[2] <= n2_u.z * l_dly_q[D_L-1].x;
    c2p_q[3] <= n2_u.x * l_dly_q[D_L-1].z;
    c2p_q[4] <= n2_u.x * l_dly_q[D_L-1].y;
    c2p_q[5] <= n2_u.y * l_dly_q[D_L-1].x;
    u_d1_q   <= n2_u;
    l_d1_q   <= l_dly_q[D_L-1];
    r_q[0]   <= rnd_sat16({c2p_q[0][31], c2p_q[0]} - {c2p_q[1][31], c2p_q[1]});
    r_q[1]   <= rnd_sat16({c2p_q[2][31], c2p_q[2]} - {c2p_q[3][31], c2p_q[3]});
    r_q[2]   <= rnd_sat16({c2p_q[4][31], c2p_q[4]} - {c2p_q[5][31], c2p_q[5]});
    u_d2_q   <= u_d1_q;
    l_d2_q   <= l_d1_q;
  end

  // axes in output order: right, up, look
  assign ax_r[0] = r_q[0];
  assign ax_r[1] = r_q[1];
  assign ax_r[2] = r_q[2];
  assign ax_r[3] = u_d2_q.x;
  assign ax_r[4] = u_d2_q.y;
  assign ax_r[5] = u_d2_q.z;
  assign ax_r[6] = l_d2_q.x;
  assign ax_r[7] = l_d2_q.y;
  assign ax_r[8] = l_d2_q.z;

  always_ff @(posedge clk_i) begin
    for (int a = 0; a < 3; a++) begin
      for (int c = 0; c < 3; c++) begin
        dp_q[3*a+c] <= $signed(pos_dly_q[D_POS-1][c]) * ax_r[3*a+c];
      end
    end
    for (int k = 0; k < 9; k++) ax_dp_q[k] <= ax_r[k];
    for (int a = 0; a < 3; a++) begin
      ds_q[a] <= {{2{dp_q[3*a][47]}}, dp_q[3*a]}
               + {{2{dp_q[3*a+1][47]}}, dp_q[3*a+1]}
               + {{2{dp_q[3*a+2][47]}}, dp_q[3*a+2]};
    end
    ax_ds_q <= ax_dp_q;
    res_q.right_out_x <= ax_ds_q[0];
    res_q.right_out_y <= ax_ds_q[1];
    res_q.right_out_z <= ax_ds_q[2];
    res_q.up_out_x    <= ax_ds_q[3];
    res_q.up_out_y    <= ax_ds_q[4];
    res_q.up_out_z    <= ax_ds_q[5];
    res_q.look_out_x  <= ax_ds_q[6];
    res_q.look_out_y  <= ax_ds_q[7];
    res_q.look_out_z  <= ax_ds_q[8];
    res_q.trans_x     <= rnd_sat32(ds_q[0]);
    res_q.trans_y     <= rnd_sat32(ds_q[1]);
    res_q.trans_z     <= rnd_sat32(ds_q[2]);
  end

  // valid bits travel beside the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q    <= 1'b0;
      c1p_v_q <= 1'b0;
      c1d_v_q <= 1'b0;
      c2p_v_q <= 1'b0;
      r_v_q   <= 1'b0;
      dp_v_q  <= 1'b0;
      ds_v_q  <= 1'b0;
      done_q  <= 1'b0;
    end else begin
      v0_q    <= start;
      c1p_v_q <= n1_v;
      c1d_v_q <= c1p_v_q;
      c2p_v_q <= n2_v;
      r_v_q   <= c2p_v_q;
      dp_v_q  <= r_v_q;
      ds_v_q  <= dp_v_q;
      done_q  <= ds_v_q;
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

`ifndef SYNTHESIS
  // each request yields exactly one result after the fixed latency
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o == $past(start && rst_ni, TOTAL_LAT))
    else $error("result strobe out of step with requests");

  // zero-length look clears every other output
  a_zero_look: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && res_o.look_out_x == 16'sd0 && res_o.look_out_y == 16'sd0
      && res_o.look_out_z == 16'sd0)
    |-> (res_o.up_out_x == 16'sd0 && res_o.up_out_y == 16'sd0
      && res_o.up_out_z == 16'sd0 && res_o.right_out_x == 16'sd0
      && res_o.right_out_y == 16'sd0 && res_o.right_out_z == 16'sd0
      && res_o.trans_x == 32'sd0 && res_o.trans_y == 32'sd0
      && res_o.trans_z == 32'sd0))
    else $error("zero look did not clear the axes");

  // normalized components never exceed one
  a_unit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (res_o.look_out_x >= -16'sd16384 && res_o.look_out_x <= 16'sd16384
      && res_o.look_out_y >= -16'sd16384 && res_o.look_out_y <= 16'sd16384
      && res_o.look_out_z >= -16'sd16384 && res_o.look_out_z <= 16'sd16384
      && res_o.up_out_x >= -16'sd16384 && res_o.up_out_x <= 16'sd16384
      && res_o.up_out_y >= -16'sd16384 && res_o.up_out_y <= 16'sd16384
      && res_o.up_out_z >= -16'sd16384 && res_o.up_out_z <= 16'sd16384))
    else $error("normalized component out of range");
`endif

endmodule

`default_nettype wire

// ----- verif/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top: testbench for camera_view_matrix_build_core
// drives camera requests with random idle gaps, predicts the view axes and
// translations of every request and checks each strobed result in order
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
  import cvm_pkg::*;

  localparam int unsigned CLK_HALF   = 5;
  localparam int unsigned RST_CYCLES = 12;
  localparam int unsigned N_RANDOM   = 1830;
  localparam int unsigned MAX_ERRS   = 10;
  localparam longint      CYCLE_CAP  = 200000;

  typedef longint vec3_t [3];

  logic     clk_i   = 1'b0;
  logic     rst_ni  = 1'b0;
  logic     start   = 1'b0;
  logic     busy;
  cvm_req_t req_i   = '0;
  logic     done_o;
  cvm_res_t res_o;

  // results predicted for accepted requests, oldest first
  cvm_res_t view_q[$];
  int       mismatches = 0;
  int       idle_pct   = 0;
  longint   cycles     = 0;

  camera_view_matrix_build_core dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .res_o  (res_o)
  );

  always begin
    #CLK_HALF clk_i = 1'b1;
    #CLK_HALF clk_i = 1'b0;
  end

  // ------------------------------------------------------------------------
  // fixed-point view axis predictor
  // ------------------------------------------------------------------------

  function automatic longint unsigned int_sqrt(input longint unsigned x);
    longint unsigned r;
    longint unsigned b;
    r = 0;
    b = 64'd1 << 62;
    while (b > x) b = b >> 2;
    while (b != 0) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic longint clamp(input longint v, input longint lo, input longint hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  // divide by 2^sh, halves rounded away from zero
  function automatic longint round_shift(input longint x, input int sh);
    longint unsigned mag;
    mag = (x < 0) ? longint'(-x) : x;
    mag = (mag + (64'd1 << (sh - 1))) >> sh;
    return (x < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic vec3_t unit_vec(input vec3_t v);
    longint unsigned mag [3];
    bit              neg [3];
    longint unsigned m, s, q, r;
    vec3_t           o;
    m = 0;
    s = 0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = v[i] < 0;
      mag[i] = neg[i] ? longint'(-v[i]) : v[i];
      mag[i] = mag[i] & 64'hffff_ffff;
      if (mag[i] > m) m = mag[i];
    end
    // a zero-length vector maps to zero
    if (m == 0) begin
      o = '{0, 0, 0};
      return o;
    end
    // bring the largest magnitude into [2^14, 2^15)
    while (m >= (64'd1 << 15)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
      m = m >> 1;
    end
    while (m < (64'd1 << 14)) begin
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
      m = m << 1;
    end
    for (int i = 0; i < 3; i++) s = s + mag[i] * mag[i];
    q = int_sqrt(s << 28);
    for (int i = 0; i < 3; i++) begin
      r    = ((mag[i] << 28) + (q >> 1)) / q;
      o[i] = clamp(neg[i] ? -longint'(r) : longint'(r), -32768, 32767);
    end
    return o;
  endfunction

  function automatic vec3_t cross_prod(input vec3_t a, input vec3_t b);
    vec3_t o;
    o[0] = a[1] * b[2] - a[2] * b[1];
    o[1] = a[2] * b[0] - a[0] * b[2];
    o[2] = a[0] * b[1] - a[1] * b[0];
    return o;
  endfunction

  function automatic longint neg_dot(input vec3_t p, input vec3_t a);
    longint d;
    d = p[0] * a[0] + p[1] * a[1] + p[2] * a[2];
    return clamp(round_shift(-d, 14), -64'sd2147483648, 64'sd2147483647);
  endfunction

  function automatic cvm_res_t predict_view(input cvm_req_t r);
    vec3_t    p, lin, rin, l, u, rt, c;
    cvm_res_t o;
    p   = '{longint'(r.pos_x), longint'(r.pos_y), longint'(r.pos_z)};
    lin = '{longint'(r.look_in_x), longint'(r.look_in_y), longint'(r.look_in_z)};
    rin = '{longint'(r.right_in_x), longint'(r.right_in_y), longint'(r.right_in_z)};
    l   = unit_vec(lin);
    u   = unit_vec(cross_prod(l, rin));
    // right axis is up x look, rounded but not renormalized
    c   = cross_prod(u, l);
    for (int i = 0; i < 3; i++) rt[i] = clamp(round_shift(c[i], 14), -32768, 32767);
    o.right_out_x = rt[0];
    o.right_out_y = rt[1];
    o.right_out_z = rt[2];
    o.up_out_x    = u[0];
    o.up_out_y    = u[1];
    o.up_out_z    = u[2];
    o.look_out_x  = l[0];
    o.look_out_y  = l[1];
    o.look_out_z  = l[2];
    o.trans_x     = neg_dot(p, rt);
    o.trans_y     = neg_dot(p, u);
    o.trans_z     = neg_dot(p, l);
    return o;
  endfunction

  // ------------------------------------------------------------------------
  // request monitor and result checker, both sampled at the rising edge
  // ------------------------------------------------------------------------

  always @(posedge clk_i) begin
    if (rst_ni && start && !busy) begin
      view_q.push_back(predict_view(req_i));
    end
  end

  always @(posedge clk_i) begin
    cvm_res_t exp_res;
    longint   ev [12];
    longint   av [12];
    string    names [12];
    if (rst_ni && done_o) begin
      if (view_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_ERRS) $display("unexpected result at cycle %0d", cycles);
      end else begin
        exp_res = view_q.pop_front();
        names = '{"right_out_x", "right_out_y", "right_out_z", "up_out_x", "up_out_y",
                  "up_out_z", "look_out_x", "look_out_y", "look_out_z", "trans_x",
                  "trans_y", "trans_z"};
        ev = '{exp_res.right_out_x, exp_res.right_out_y, exp_res.right_out_z,
               exp_res.up_out_x, exp_res.up_out_y, exp_res.up_out_z,
               exp_res.look_out_x, exp_res.look_out_y, exp_res.look_out_z,
               exp_res.trans_x, exp_res.trans_y, exp_res.trans_z};
        av = '{res_o.right_out_x, res_o.right_out_y, res_o.right_out_z,
               res_o.up_out_x, res_o.up_out_y, res_o.up_out_z,
               res_o.look_out_x, res_o.look_out_y, res_o.look_out_z,
               res_o.trans_x, res_o.trans_y, res_o.trans_z};
        for (int i = 0; i < 12; i++) begin
          if (ev[i] != av[i]) begin
            mismatches++;
            if (mismatches <= MAX_ERRS) begin
              $display("mismatch %s at cycle %0d: expected %0d, got %0d",
                       names[i], cycles, ev[i], av[i]);
            end
          end
        end
      end
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_CAP) begin
      $display("camera_view_matrix_build_core verification failed");
      $finish;
    end
  end

  // ------------------------------------------------------------------------
  // stimulus
  // ------------------------------------------------------------------------

  // send one request, with a random idle gap ahead of it
  task automatic send_request(input cvm_req_t r);
    // each cycle idles with probability idle_pct percent
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    forever begin
      @(negedge clk_i);
      if (!busy) break;
    end
    @(posedge clk_i);
  endtask

  function automatic cvm_req_t make_req(input int px, input int py, input int pz,
                                        input shortint lx, input shortint ly,
                                        input shortint lz, input shortint rx,
                                        input shortint ry, input shortint rz);
    cvm_req_t r;
    r = '{px, py, pz, lx, ly, lz, rx, ry, rz};
    return r;
  endfunction

  // direction component: full range, small magnitude or zero
  function automatic shortint rand_dir();
    case ($urandom_range(9))
      0:       return 16'sd0;
      1, 2:    return shortint'($signed($urandom_range(0, 63)) - 32);
      3:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      default: return shortint'($urandom);
    endcase
  endfunction

  function automatic int rand_pos();
    case ($urandom_range(7))
      0:       return $urandom_range(1) ? 32'sh7fff_ffff : 32'sh8000_0000;
      1:       return $signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000;
      default: return int'($urandom);
    endcase
  endfunction

  task automatic test_directed();
    idle_pct = 35;
    // zero-length look
    send_request(make_req(32'sh0001_0000, 32'sh0002_0000, -32'sh0003_0000,
                          0, 0, 0, 16384, 0, 0));
    send_request(make_req(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                          0, 0, 0, 0, 0, 0));
    // look parallel to right, and antiparallel
    send_request(make_req(32'sh0005_0000, -32'sh0001_0000, 32'sh0000_8000,
                          0, 0, 16384, 0, 0, 8000));
    send_request(make_req(32'sh0005_0000, 32'sh0001_0000, 32'sh0000_8000,
                          1000, 2000, -3000, -2000, -4000, 6000));
    // zero right
    send_request(make_req(32'sh0001_0000, 0, 0, 100, 200, 300, 0, 0, 0));
    // translation saturation both ways
    send_request(make_req(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
                          16384, 16384, 16384, 0, 16384, -16384));
    send_request(make_req(32'sh7fff_ffff, 32'sh7fff_ffff, 32'sh7fff_ffff,
                          16384, 16384, 16384, 0, 16384, -16384));
    send_request(make_req(32'sh8000_0000, 0, 0, 16384, 0, 0, 0, 16384, 0));
    send_request(make_req(32'sh7fff_ffff, 0, 0, 16384, 0, 0, 0, 16384, 0));
    // extremes of the direction fields
    send_request(make_req(32'sh7fff_ffff, 32'sh8000_0000, 0,
                          16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh8000, 16'sh7fff, 0));
    send_request(make_req(32'sh8000_0000, 32'sh7fff_ffff, -1,
                          16'sh8000, 16'sh8000, 16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff));
    send_request(make_req(-1, -1, -1, 16'sh8000, 0, 0, 0, 0, 16'sh8000));
    send_request(make_req(1, 1, 1, 0, 16'sh7fff, 0, 16'sh7fff, 0, 0));
    // tiny vectors that need scaling up
    send_request(make_req(32'sh0010_0000, 32'sh0020_0000, 32'sh0030_0000,
                          1, 0, 0, 0, 1, 0));
    send_request(make_req(32'sh0010_0000, -32'sh0020_0000, 32'sh0030_0000,
                          -1, 1, -1, 1, 1, 0));
    send_request(make_req(0, 0, 0, 3, -5, 7, -2, 9, 1));
    // ordinary camera
    send_request(make_req(32'sh0004_0000, 32'sh0002_0000, 32'sh000a_0000,
                          0, 0, -16384, 16384, 0, 0));
    start <= 1'b0;
  endtask

  task automatic test_random(input int pct, input int count);
    cvm_req_t r;
    shortint  k;
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      r = make_req(rand_pos(), rand_pos(), rand_pos(), rand_dir(), rand_dir(), rand_dir(),
                   rand_dir(), rand_dir(), rand_dir());
      // now and then make right a scaled copy of look
      if ($urandom_range(19) == 0) begin
        k = shortint'($urandom_range(0, 6)) - 3;
        r.right_in_x = r.look_in_x * k;
        r.right_in_y = r.look_in_y * k;
        r.right_in_z = r.look_in_z * k;
      end
      send_request(r);
    end
    start <= 1'b0;
  endtask

  initial begin
    repeat (RST_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random(35, N_RANDOM / 3);
    test_random(88, N_RANDOM / 3);
    test_random(0, N_RANDOM / 3);

    // drain, then allow the pipeline to go quiet
    while (view_q.size() != 0) @(posedge clk_i);
    repeat (TOTAL_LAT + 16) @(posedge clk_i);

    if (mismatches == 0) begin
      $display("camera_view_matrix_build_core verification clean");
    end else begin
      $display("camera_view_matrix_build_core verification failed");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ----- camera_view_matrix_build_core.f -----
rtl/cvm_pkg.sv
rtl/cvm_norm3.sv
rtl/camera_view_matrix_build_core.sv
verif/tb_top.sv
